/* rtl/sobol_pkg.sv */
// Shared types, constants and codes for the Sobol point generator.
package sobol_pkg;

  localparam int unsigned MAX_ROWS   = 65536;
  localparam int unsigned MAX_DEGREE = 20;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned N_WORDS    = 32;

  localparam int unsigned DEG_W   = 5;
  localparam int unsigned POLY_W  = 19;
  localparam int unsigned ROWS_W  = 17;
  localparam int unsigned M_W     = 20;
  localparam int unsigned PIDX_W  = 16;
  localparam int unsigned CFG_DW  = 19;
  localparam int unsigned IDX_W   = $clog2(MAX_ROWS + 1);
  localparam int unsigned ADDR_W  = $clog2(N_WORDS);
  localparam int unsigned EXP_CW  = $clog2(N_WORDS + 1);
  localparam int unsigned M_AW    = $clog2(MAX_DEGREE);

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_NEXT    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_DEGREE    = 2'd0,
    CFG_POLY_BITS = 2'd1,
    CFG_FIRST_DIM = 2'd2,
    CFG_ROW_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_STEP   = 2'd1,
    S_EXPAND = 2'd2
  } state_e;

  typedef struct packed {
    kind_e            kind;
    logic [DEG_W-1:0] m_index;
    logic [M_W-1:0]   m_value;
  } item_in_t;

  typedef struct packed {
    logic [WORD_W-1:0] point;
    logic [PIDX_W-1:0] point_index;
    logic              exhausted;
  } item_out_t;

  typedef struct packed {
    logic [DEG_W-1:0]  degree;
    logic [POLY_W-1:0] poly_bits;
    logic              first_dimension;
    logic [ROWS_W-1:0] row_count;
  } cfg_t;

  typedef struct packed {
    logic load_m;
    logic capture;
    logic apply;
    logic exp_init;
    logic exp_step;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_last;
  } dp_status_t;

endpackage

/* rtl/sobol_point_generator_core.sv */
// Top level of the Sobol point generator: configuration registers and wiring.
//
// Generates one dimension of a 32-bit Sobol sequence in Gray-code order. An
// item is taken when start is high and busy is low. A load item (m word) is
// absorbed in the accepting cycle and busy stays low. A next item raises busy
// for one cycle; its result appears on result_o with result_valid_o high in
// the cycle right after acceptance, so no new item is taken while the result
// shows. The step state is there for the registered read of the single-port
// direction word RAM. A restart item clears point and index when taken and
// keeps busy high while the expansion writes one direction word per cycle into
// that RAM. The result strobe lasts exactly one cycle and cannot be held off:
// take it when it shows. Configuration writes are always ready and should be
// issued only while the block is idle; they reach the direction words at the
// next restart.
module sobol_point_generator_core
  import sobol_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_in_t          item_i,
  output logic              result_valid_o,
  output item_out_t         result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  cfg_idx_e          cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // register writes: take the low bits the register holds
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEGREE:    cfg_d.degree          = cfg_data_i[DEG_W-1:0];
        CFG_POLY_BITS: cfg_d.poly_bits       = cfg_data_i[POLY_W-1:0];
        CFG_FIRST_DIM: cfg_d.first_dimension = cfg_data_i[0];
        CFG_ROW_COUNT: cfg_d.row_count       = cfg_data_i[ROWS_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degree          <= DEG_W'(1);
      cfg_q.poly_bits       <= '0;
      cfg_q.first_dimension <= 1'b1;
      cfg_q.row_count       <= ROWS_W'(MAX_ROWS);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sobol_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .kind_i         (item_i.kind),
    .status_i       (status),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  sobol_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

/* rtl/sobol_ctrl.sv */
// Control state machine: sequences loads, point steps and direction expansion.
module sobol_ctrl
  import sobol_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  kind_e      kind_i,
  input  dp_status_t status_i,
  output logic       busy,
  output logic       result_valid_o,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (kind_i)
            KIND_LOAD: begin
              cmd_o.load_m = 1'b1;
            end
            KIND_RESTART: begin
              cmd_o.exp_init = 1'b1;
              state_d        = S_EXPAND;
            end
            KIND_NEXT: begin
              cmd_o.capture = 1'b1;
              state_d       = S_STEP;
            end
            KIND_NONE: begin
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_STEP: begin
        // strobe the captured item and fold in the direction word
        result_valid_o = 1'b1;
        cmd_o.apply    = 1'b1;
        state_d        = S_IDLE;
      end
      S_EXPAND: begin
        cmd_o.exp_step = 1'b1;
        if (status_i.exp_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sobol_datapath.sv */
// Datapath: initial values, direction word RAM, expansion window and point state.
module sobol_datapath
  import sobol_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  item_in_t   item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output item_out_t  result_o
);

  // stores
  logic [M_W-1:0]    m_mem   [MAX_DEGREE];
  logic [WORD_W-1:0] dir_mem [N_WORDS];
  logic [WORD_W-1:0] win_q   [MAX_DEGREE];

  logic [WORD_W-1:0] point_q, point_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [EXP_CW-1:0] exp_i_q, exp_i_d;
  logic [WORD_W-1:0] rd_q;
  item_out_t         res_q;

  logic [DEG_W-1:0]  s_eff;
  logic [IDX_W-1:0]  rows_eff;
  logic              exh;
  logic [ADDR_W-1:0] tz_addr;
  logic              tz_found;
  logic [EXP_CW-1:0] sh_amt;
  logic [M_AW-1:0]   m_rd_addr;
  logic [WORD_W-1:0] m_word;
  logic [WORD_W-1:0] unit_word;
  logic [WORD_W-1:0] tap_s;
  logic [WORD_W-1:0] rec_word;
  logic [WORD_W-1:0] new_word;
  logic [DEG_W-1:0]  pidx;
  logic              m_wr_ok;

  // clamp degree into 1..MAX_DEGREE
  always_comb begin
    if (cfg_i.degree == '0) begin
      s_eff = DEG_W'(1);
    end else if (cfg_i.degree > DEG_W'(MAX_DEGREE)) begin
      s_eff = DEG_W'(MAX_DEGREE);
    end else begin
      s_eff = cfg_i.degree;
    end
  end

  // clamp row count into 1..MAX_ROWS
  always_comb begin
    if (cfg_i.row_count == '0) begin
      rows_eff = IDX_W'(1);
    end else if (IDX_W'(cfg_i.row_count) > IDX_W'(MAX_ROWS)) begin
      rows_eff = IDX_W'(MAX_ROWS);
    end else begin
      rows_eff = IDX_W'(cfg_i.row_count);
    end
  end

  assign exh = (idx_q >= rows_eff);

  // lowest zero bit of the index picks the direction word
  always_comb begin
    tz_addr  = '0;
    tz_found = 1'b0;
    for (int b = 0; b < IDX_W; b++) begin
      if (!tz_found) begin
        if (idx_q[b]) begin
          tz_addr = ADDR_W'(b + 1);
        end else begin
          tz_found = 1'b1;
        end
      end
    end
  end

  // expansion word for position exp_i_q
  assign sh_amt    = EXP_CW'(N_WORDS) - exp_i_q;
  assign m_rd_addr = (exp_i_q <= EXP_CW'(MAX_DEGREE)) ?
                     M_AW'(exp_i_q - EXP_CW'(1)) : '0;
  assign m_word    = WORD_W'(m_mem[m_rd_addr]) << sh_amt[ADDR_W-1:0];
  assign unit_word = WORD_W'(1) << sh_amt[ADDR_W-1:0];
  assign tap_s     = win_q[M_AW'(s_eff - DEG_W'(1))];

  always_comb begin
    rec_word = tap_s ^ (tap_s >> s_eff);
    pidx     = '0;
    for (int k = 1; k < MAX_DEGREE; k++) begin
      pidx = s_eff - DEG_W'(1) - DEG_W'(k);
      if ((DEG_W'(k) < s_eff) && cfg_i.poly_bits[pidx]) begin
        rec_word = rec_word ^ win_q[k-1];
      end
    end
  end

  always_comb begin
    if (cfg_i.first_dimension) begin
      new_word = unit_word;
    end else if (exp_i_q <= EXP_CW'(s_eff)) begin
      new_word = m_word;
    end else begin
      new_word = rec_word;
    end
  end

  assign status_o.exp_last = (exp_i_q == EXP_CW'(N_WORDS));

  // control-state next values
  always_comb begin
    point_d = point_q;
    idx_d   = idx_q;
    exp_i_d = exp_i_q;
    if (cmd_i.exp_init) begin
      point_d = '0;
      idx_d   = '0;
      exp_i_d = EXP_CW'(1);
    end else if (cmd_i.exp_step) begin
      exp_i_d = exp_i_q + EXP_CW'(1);
    end else if (cmd_i.apply && !res_q.exhausted) begin
      point_d = point_q ^ rd_q;
      idx_d   = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
      idx_q   <= '0;
      exp_i_q <= EXP_CW'(1);
    end else begin
      point_q <= point_d;
      idx_q   <= idx_d;
      exp_i_q <= exp_i_d;
    end
  end

  assign m_wr_ok = (item_i.m_index != '0) && (item_i.m_index <= DEG_W'(MAX_DEGREE));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_m && m_wr_ok) begin
      m_mem[M_AW'(item_i.m_index - DEG_W'(1))] <= item_i.m_value;
    end
  end

  // direction RAM: one write port for expansion, registered read for steps
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      dir_mem[ADDR_W'(exp_i_q - EXP_CW'(1))] <= new_word;
    end
    if (cmd_i.capture) begin
      rd_q <= dir_mem[tz_addr];
    end
  end

  // window of the most recent words: win_q[j] is word i-1-j
  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_step) begin
      win_q[0] <= new_word;
      for (int j = 1; j < MAX_DEGREE; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_q.exhausted   <= exh;
      res_q.point       <= exh ? '0 : point_q;
      res_q.point_index <= exh ? '0 : idx_q[PIDX_W-1:0];
    end
  end

  assign result_o = res_q;

endmodule

/* bench/sobol_point_generator_core_tb.sv */
// Self-checking testbench for the Sobol point generator core.
`timescale 1ns / 100ps

module sobol_point_generator_core_tb;
  import sobol_pkg::*;

  localparam int N_PHASES        = 16;
  localparam int ITEMS_PER_PHASE = 85;
  // Restart keeps the core busy while it expands and yields no result; pad it.
  localparam int SETTLE_CYCLES   = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_in_t          item_i;
  logic              result_valid_o;
  item_out_t         result_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  cfg_idx_e          cfg_index_i;
  logic [CFG_DW-1:0] cfg_data_i;

  sobol_point_generator_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run, including the long gaps.
  initial begin
    #2_000_000;
    $display("sobol_point_generator_core_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the generator: registers, stores, point and index.
  // ---------------------------------------------------------------------------
  logic [DEG_W-1:0]  sh_degree;
  logic [POLY_W-1:0] sh_poly;
  logic              sh_first;
  logic [ROWS_W-1:0] sh_rows;
  logic [WORD_W-1:0] dir_tab [1:N_WORDS];
  logic [M_W-1:0]    m_tab   [1:MAX_DEGREE];
  logic [WORD_W-1:0] cur_pt;
  logic [IDX_W-1:0]  cur_idx;

  item_out_t points_due [$];   // points still owed by the core, oldest first
  int        n_bad;
  bit        no_gaps;

  // Clamp the degree to the range the recurrence supports.
  function automatic int degree_used(input logic [DEG_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DEGREE) return MAX_DEGREE;
    return int'(d);
  endfunction

  // Rebuild the 32 direction words from the current settings, then rewind.
  function automatic void build_dir_words();
    int s;
    logic [WORD_W-1:0] w, v;
    if (sh_first) begin
      for (int i = 1; i <= N_WORDS; i++) dir_tab[i] = 32'd1 << (32 - i);
    end else begin
      s = degree_used(sh_degree);
      for (int i = 1; i <= s; i++) dir_tab[i] = 32'(m_tab[i]) << (32 - i);
      for (int i = s + 1; i <= N_WORDS; i++) begin
        w = dir_tab[i - s];
        v = w ^ (w >> s);
        for (int k = 1; k < s; k++) begin
          if (sh_poly[s - 1 - k]) v ^= dir_tab[i - k];
        end
        dir_tab[i] = v;
      end
    end
    cur_pt  = '0;
    cur_idx = '0;
  endfunction

  // Advance the shadow by one accepted item; return 1 when a point is due.
  function automatic bit sobol_step(input item_in_t it, output item_out_t pt);
    int rows_eff, c;
    logic [IDX_W-1:0] v;
    pt = '0;
    case (it.kind)
      KIND_LOAD: begin
        if (it.m_index >= 1 && it.m_index <= MAX_DEGREE) m_tab[it.m_index] = it.m_value;
        return 1'b0;
      end
      KIND_RESTART: begin
        build_dir_words();
        return 1'b0;
      end
      KIND_NEXT: begin
        rows_eff = (sh_rows == 0) ? 1 : (sh_rows > MAX_ROWS) ? MAX_ROWS : int'(sh_rows);
        if (int'(cur_idx) >= rows_eff) begin
          pt.exhausted = 1'b1;
          return 1'b1;
        end
        pt.point       = cur_pt;
        pt.point_index = cur_idx[PIDX_W-1:0];
        // Gray-code step: pick the word of the lowest clear index bit.
        c = 1;
        v = cur_idx;
        while (v[0] && c < 32) begin
          v = v >> 1;
          c++;
        end
        cur_pt  ^= dir_tab[c];
        cur_idx += 1;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Idle in about 35 of a hundred items; now and then a long gap that spans
  // most of an expansion.
  function automatic int pick_gap();
    if (no_gaps || $urandom_range(99) >= 35) return 0;
    if ($urandom_range(7) == 0) return $urandom_range(4, 40);
    return $urandom_range(1, 3);
  endfunction

  // Offer one item, hold it until taken, then log the point it owes.
  // Leave start high: the next call or wait_idle decides in the same step.
  task automatic drive_item(input item_in_t it, input bit typed, input item_out_t want);
    int gap;
    item_out_t pt;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (sobol_step(it, pt)) points_due.push_back(typed ? want : pt);
  endtask

  // Drop start, drain every owed point and let a trailing restart finish.
  task automatic wait_idle();
    start <= 1'b0;
    while (points_due.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] data);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DEGREE:    sh_degree = data[DEG_W-1:0];
      CFG_POLY_BITS: sh_poly   = data[POLY_W-1:0];
      CFG_FIRST_DIM: sh_first  = data[0];
      CFG_ROW_COUNT: sh_rows   = data[ROWS_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // Well-formed m values half the time (odd, below 2^pos), otherwise any 20 bits.
  function automatic logic [M_W-1:0] pick_m(input int pos);
    logic [M_W-1:0] m;
    m = M_W'($urandom);
    if ($urandom_range(1)) begin
      if (pos < M_W) m = m & ((M_W'(1) << pos) - 1);
      m[0] = 1'b1;
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: the core cannot be stalled, so take every strobe.
  // ---------------------------------------------------------------------------
  function automatic void note_bad(input string what, input logic [WORD_W-1:0] exp_v,
                                   input logic [WORD_W-1:0] got_v);
    n_bad++;
    if (n_bad <= 10)
      $display("%0t: %s mismatch, expected %h got %h", $time, what, exp_v, got_v);
  endfunction

  always @(posedge clk_i) begin : check_points
    item_out_t want;
    if (rst_ni && result_valid_o) begin
      if (points_due.size() == 0) begin
        note_bad("unexpected point", '0, result_o.point);
      end else begin
        want = points_due.pop_front();
        if (result_o.point !== want.point) note_bad("point", want.point, result_o.point);
        if (result_o.point_index !== want.point_index)
          note_bad("point_index", 32'(want.point_index), 32'(result_o.point_index));
        if (result_o.exhausted !== want.exhausted)
          note_bad("exhausted", 32'(want.exhausted), 32'(result_o.exhausted));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                is_reg;
    cfg_idx_e          reg_idx;
    logic [CFG_DW-1:0] data;
    item_in_t          it;
    bit                typed;
    item_out_t         want;
  } step_row_t;

  function automatic step_row_t on_item(input kind_e k, input logic [DEG_W-1:0] pos,
                                        input logic [M_W-1:0] val);
    step_row_t r;
    r = '{default: '0, reg_idx: CFG_DEGREE, it: '0, want: '0};
    r.it.kind    = k;
    r.it.m_index = pos;
    r.it.m_value = val;
    return r;
  endfunction

  function automatic step_row_t with_want(input step_row_t r, input logic [WORD_W-1:0] pt,
                                          input logic [PIDX_W-1:0] idx, input logic ex);
    r.typed            = 1'b1;
    r.want.point       = pt;
    r.want.point_index = idx;
    r.want.exhausted   = ex;
    return r;
  endfunction

  function automatic step_row_t on_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] data);
    step_row_t r;
    r = '{default: '0, reg_idx: CFG_DEGREE, it: '0, want: '0};
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.data    = data;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    step_row_t         plan [$];
    item_in_t          it;
    logic [DEG_W-1:0]  deg;
    logic [POLY_W-1:0] poly;
    logic              first;
    logic [ROWS_W-1:0] rows;
    int                counted, s, pick;

    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DEGREE;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    n_bad       = 0;
    no_gaps     = 1'b0;
    sh_degree   = 5'd1;
    sh_poly     = '0;
    sh_first    = 1'b1;
    sh_rows     = ROWS_W'(MAX_ROWS);
    cur_pt      = '0;
    cur_idx     = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out-of-range load positions and the none kind: all dropped.
    plan.push_back(on_item(KIND_LOAD, 5'd0, 20'hFFFFF));
    plan.push_back(on_item(KIND_LOAD, 5'd21, 20'h05555));
    plan.push_back(on_item(KIND_LOAD, 5'd31, 20'hAAAAA));
    plan.push_back(on_item(KIND_NONE, 5'd5, 20'h12345));
    // Reset settings: first-dimension words, the full row budget.
    plan.push_back(on_item(KIND_RESTART, 5'd0, 20'h0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h0, 16'd0, 1'b0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd31, 20'hFFFFF), 32'h8000_0000, 16'd1, 1'b0));
    plan.push_back(on_item(KIND_NEXT, 5'd0, 20'h0));
    // A row count of zero behaves as one: already spent, so exhausted at once.
    plan.push_back(on_reg(CFG_ROW_COUNT, CFG_DW'(0)));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h0, 16'd0, 1'b1));
    // Two rows, then exhaustion.
    plan.push_back(on_reg(CFG_ROW_COUNT, CFG_DW'(2)));
    plan.push_back(on_item(KIND_RESTART, 5'd0, 20'h0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h0, 16'd0, 1'b0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h8000_0000, 16'd1, 1'b0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h0, 16'd0, 1'b1));
    // Polynomial mode, degree zero taken as one, all poly bits set, row
    // count above the maximum; wide m values lose their top bits.
    plan.push_back(on_reg(CFG_FIRST_DIM, CFG_DW'(0)));
    plan.push_back(on_reg(CFG_DEGREE, CFG_DW'(0)));
    plan.push_back(on_reg(CFG_POLY_BITS, CFG_DW'(19'h7FFFF)));
    plan.push_back(on_reg(CFG_ROW_COUNT, CFG_DW'(131071)));
    plan.push_back(on_item(KIND_LOAD, 5'd1, 20'h00001));
    plan.push_back(on_item(KIND_LOAD, 5'd15, 20'hFFFFF));
    plan.push_back(on_item(KIND_LOAD, 5'd20, 20'hFFFFF));
    plan.push_back(on_item(KIND_RESTART, 5'd0, 20'h0));
    plan.push_back(with_want(on_item(KIND_NEXT, 5'd0, 20'h0), 32'h0, 16'd0, 1'b0));
    repeat (3) plan.push_back(on_item(KIND_NEXT, 5'd0, 20'h0));

    foreach (plan[n]) begin
      if (plan[n].is_reg) write_reg(plan[n].reg_idx, plan[n].data);
      else drive_item(plan[n].it, plan[n].typed, plan[n].want);
    end

    // Random phases: settings first, then load m, restart and mostly points.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      deg   = DEG_W'($urandom_range(1, 20));
      poly  = POLY_W'($urandom);
      first = ($urandom_range(3) == 0);
      pick  = $urandom_range(99);
      rows  = (pick < 70) ? ROWS_W'($urandom_range(1, 40)) : ROWS_W'($urandom_range(0, 131071));
      case (ph)
        0: begin deg = 5'd20; poly = 19'h7FFFF; first = 1'b0; rows = ROWS_W'(MAX_ROWS); end
        1: begin deg = 5'd31; poly = '0;        first = 1'b0; rows = 17'd1;            end
        2: begin deg = 5'd0;  poly = 19'h7FFFF; first = 1'b0; rows = 17'd131071;       end
        3: begin deg = 5'd1;                    first = 1'b1; rows = 17'd0;            end
        4: first = 1'b0;
        default: if ($urandom_range(4) == 0) deg = DEG_W'($urandom_range(21, 31));
      endcase
      no_gaps = (ph == 4);   // one long stretch without idle cycles

      write_reg(CFG_DEGREE, CFG_DW'(deg));
      write_reg(CFG_POLY_BITS, CFG_DW'(poly));
      write_reg(CFG_FIRST_DIM, CFG_DW'(first));
      write_reg(CFG_ROW_COUNT, CFG_DW'(rows));

      // Load every m the recurrence will read before the first restart.
      counted = 0;
      s = degree_used(deg);
      if (!first) begin
        for (int p = 1; p <= s; p++) begin
          it.kind    = KIND_LOAD;
          it.m_index = DEG_W'(p);
          it.m_value = pick_m(p);
          drive_item(it, 1'b0, '0);
          counted++;
        end
      end
      it         = item_in_t'($urandom);
      it.kind    = KIND_RESTART;
      drive_item(it, 1'b0, '0);
      counted++;

      while (counted < ITEMS_PER_PHASE) begin
        it   = item_in_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 72) begin
          it.kind = KIND_NEXT;
          counted++;
        end else if (pick < 80) begin
          it.kind    = KIND_LOAD;
          it.m_index = DEG_W'($urandom_range(1, MAX_DEGREE));
          it.m_value = pick_m(int'(it.m_index));
          counted++;
        end else if (pick < 84) begin
          it.kind = KIND_RESTART;
          counted++;
        end else if (pick < 92) begin
          // Noise: a load to a position that does not exist.
          it.kind    = KIND_LOAD;
          it.m_index = ($urandom_range(3) == 0) ? 5'd0 : DEG_W'($urandom_range(21, 31));
          counted++;
        end else begin
          it.kind = KIND_NONE;
          counted++;
        end
        drive_item(it, 1'b0, '0);
      end
    end

    no_gaps = 1'b0;
    wait_idle();
    if (n_bad == 0 && points_due.size() == 0) begin
      $display("sobol_point_generator_core_tb: PASS");
    end else begin
      $display("sobol_point_generator_core_tb: FAIL");
    end
    $finish;
  end

endmodule
